@@ rtl/lfid_pkg.sv @@
package lfid_pkg;

    localparam int NUM_IDS   = 1024;
    localparam int WORD_W    = 32;
    localparam int BIT_AW    = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ID_W      = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
    localparam int REL_W     = 10;
    localparam int GIVEN_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Bits of the last word that lie beyond the pool read as used.
    localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_PAD = ~({WORD_W{1'b1}} >> (WORD_W - LAST_BITS));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef struct packed {
        logic    load_alloc;
        logic    load_free;
        logic    step;
        logic    commit_set;
        logic    commit_clr;
        logic    clear_wr;
        logic    emit;
        logic    emit_id;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_word;
        logic bit_set;
        logic in_range;
    } sts_t;

    function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/lfid_ram.sv @@
module lfid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lfid_datapath.sv @@
module lfid_datapath import lfid_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [REL_W-1:0]   release_id,
    output sts_t               sts,
    output logic [GIVEN_W-1:0] given_id,
    output status_t            status
);

    logic [WORD_AW-1:0]  word_reg, word_next;
    logic [ID_W-1:0]     ptr_reg, ptr_next;
    logic [ID_W-1:0]     rel_id_reg;
    logic [BIT_AW-1:0]   off_reg;
    logic                range_reg;
    logic [GIVEN_W-1:0]  given_reg;
    status_t             status_reg;
    logic [ID_W-1:0]     rel_id;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   eff_word;
    logic [WORD_W-1:0]   wr_data;
    logic [BIT_AW-1:0]   zero_idx;
    logic [ID_W-1:0]     found_id;
    logic                we;

    assign rel_id   = ID_W'(release_id);
    assign eff_word = rd_data | ((word_reg == LAST_WORD) ? LAST_PAD : '0);
    assign zero_idx = first_zero(eff_word);
    assign found_id = ID_W'({word_reg, zero_idx});

    assign sts.hit       = ~&eff_word;
    assign sts.last_word = (word_reg == LAST_WORD);
    assign sts.bit_set   = rd_data[off_reg];
    assign sts.in_range  = range_reg;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.load_alloc)
        begin
            word_next = WORD_AW'(ptr_reg >> BIT_AW);
        end
        else if (cmd.load_free)
        begin
            word_next = WORD_AW'(rel_id >> BIT_AW);
        end
        else if (cmd.step || cmd.clear_wr)
        begin
            word_next = word_reg + 1'b1;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.commit_set)
        begin
            ptr_next = found_id;
        end
        else if (cmd.commit_clr && (rel_id_reg < ptr_reg))
        begin
            ptr_next = rel_id_reg;
        end
    end

    always_comb
    begin
        wr_data = '0;
        if (cmd.commit_set)
        begin
            wr_data = rd_data | (WORD_W'(1) << zero_idx);
        end
        else if (cmd.commit_clr)
        begin
            wr_data = rd_data & ~(WORD_W'(1) << off_reg);
        end
    end

    assign we = cmd.commit_set | cmd.commit_clr | cmd.clear_wr;

    lfid_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(word_reg),
        .wdata(wr_data),
        .raddr(word_next),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_free)
        begin
            rel_id_reg <= rel_id;
            off_reg    <= BIT_AW'(rel_id);
            range_reg  <= (32'(release_id) < NUM_IDS);
        end
        if (cmd.emit)
        begin
            given_reg  <= cmd.emit_id ? GIVEN_W'(found_id) : '0;
            status_reg <= cmd.status;
        end
    end

    assign given_id = given_reg;
    assign status   = status_reg;

endmodule

@@ rtl/lfid_ctrl.sv @@
module lfid_ctrl import lfid_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_func,
    output logic s_tready,
    input  logic m_tready,
    output logic m_tvalid,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_func == FUNC_FREE)
                    begin
                        cmd.load_free = 1'b1;
                        state_next    = S_FREE;
                    end
                    else
                    begin
                        cmd.load_alloc = 1'b1;
                        state_next     = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                if (sts.hit)
                begin
                    if (out_free)
                    begin
                        cmd.commit_set = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.emit_id    = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.last_word)
                begin
                    if (out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_FULL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FREE:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (sts.in_range && sts.bit_set)
                    begin
                        cmd.commit_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.status = ST_NOT_ALLOC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/lowest_free_id_allocator.sv @@
// Lowest free identifier allocator.
// Input channel s_*: tuser carries func (0 allocates, 1 frees), tdata carries release_id.
// Output channel m_*: one item per input item, tdata carries given_id and status.
// An allocate scans the used-mark memory one 32-bit word per cycle, starting at the
// word that holds the search pointer and stopping at a free bit or at the last word.
// The scan rate is set by the single read port of the mark memory.
// One item is in work at a time; s_tready is high only while the block is idle.
// After reset the block clears the mark memory, one word per cycle, and accepts no
// item during that pass. The result sits in an output register, so the next item is
// accepted while a result still waits. If the receiver stalls, a finished item
// waits in its final step until the output register is free and nothing is lost.
module lowest_free_id_allocator import lfid_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // release_id[9:0], zero padding
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // given_id[9:0], status[11:10], zero padding
);

    cmd_t               cmd;
    sts_t               sts;
    logic [GIVEN_W-1:0] given_id;
    status_t            status;

    lfid_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_func  (s_tuser),
        .s_tready(s_tready),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .sts     (sts),
        .cmd     (cmd)
    );

    lfid_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .release_id(s_tdata[REL_W-1:0]),
        .sts       (sts),
        .given_id  (given_id),
        .status    (status)
    );

    assign m_tdata = OUT_DATA_W'({status, given_id});

endmodule

@@ rtl/lfid_checker.sv @@
module lfid_checker import lfid_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output item dropped while stalled.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Output item changed while stalled.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[11:10] != 2'd3)
        else $error("Undefined status code.");

    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:10] != ST_OK) |-> m_tdata[9:0] == 10'd0)
        else $error("Failed request carries a nonzero identifier.");

    a_free_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("Free result appeared too early.");

endmodule

bind lowest_free_id_allocator lfid_checker u_lfid_checker (.*);

@@ verif/lowest_free_id_allocator_checker.sv @@
`timescale 1ns / 100ps

module lowest_free_id_allocator_checker import lfid_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // release_id[9:0], zero padding
    input  logic                  s_tuser,   // func
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // given_id[9:0], status[11:10], zero padding
    output int                    fail_count,
    output int                    results_owed
);

    typedef struct packed {
        logic [GIVEN_W-1:0] given_id;
        status_t            status;
    } reply_t;

    reply_t  owed_replies[$];
    bit      id_taken[NUM_IDS];
    int      scan_from;
    int      mismatch_total;
    reply_t  oldest;

    // Applies one request to the shadow pool and returns the reply it must produce.
    function automatic reply_t serve_request(input func_t op, input logic [REL_W-1:0] rel);
        reply_t r;
        int     p;
        r.given_id = '0;
        r.status   = ST_OK;
        if (op == FUNC_ALLOC)
        begin
            p = scan_from;
            while (p < NUM_IDS && id_taken[p])
            begin
                p++;
            end
            if (p < NUM_IDS)
            begin
                id_taken[p] = 1'b1;
                scan_from   = p;
                r.given_id  = GIVEN_W'(p);
            end
            else
            begin
                r.status = ST_FULL;
            end
        end
        else
        begin
            if (int'(rel) < NUM_IDS && id_taken[rel])
            begin
                id_taken[rel] = 1'b0;
                if (int'(rel) < scan_from)
                begin
                    scan_from = int'(rel);
                end
            end
            else
            begin
                r.status = ST_NOT_ALLOC;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (id_taken[i])
            begin
                id_taken[i] = 1'b0;
            end
            scan_from = 0;
            owed_replies.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                owed_replies.push_back(serve_request(func_t'(s_tuser), s_tdata[REL_W-1:0]));
            end
            if (m_tvalid && m_tready)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("result item with no request waiting: tdata %h", m_tdata);
                    mismatch_total++;
                end
                else
                begin
                    oldest = owed_replies.pop_front();
                    if (m_tdata[GIVEN_W-1:0] !== oldest.given_id)
                    begin
                        $error("given_id: expected %0d, actual %0d",
                               oldest.given_id, m_tdata[GIVEN_W-1:0]);
                        mismatch_total++;
                    end
                    if (m_tdata[GIVEN_W+STATUS_W-1:GIVEN_W] !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest.status, m_tdata[GIVEN_W+STATUS_W-1:GIVEN_W]);
                        mismatch_total++;
                    end
                end
            end
        end
        fail_count   <= mismatch_total;
        results_owed <= owed_replies.size();
    end

endmodule

@@ verif/lowest_free_id_allocator_test.sv @@
`timescale 1ns / 100ps

module lowest_free_id_allocator_test;
    import lfid_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int results_owed;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int live_ids = 0;

    lowest_free_id_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lowest_free_id_allocator_checker pool_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input func_t op, input logic [REL_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'(id);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 57;
            end
            default:
            begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
        endcase
    endtask

    initial
    begin
        int          alloc_pct;
        logic [REL_W-1:0] id;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_request(FUNC_FREE, 10'd0);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd1023);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE, 10'd1);
        send_request(FUNC_FREE, 10'd1);
        send_request(FUNC_ALLOC, 10'd512);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE, 10'd0);
        send_request(FUNC_ALLOC, 10'd1023);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_FREE, 10'd3);
        send_request(FUNC_FREE, 10'd2);
        send_request(FUNC_ALLOC, 10'd341);
        send_request(FUNC_ALLOC, 10'd682);
        send_request(FUNC_ALLOC, 10'd0);
        live_ids = 5;

        // A long, mostly-allocating stretch fills the pool and runs into full replies;
        // the later stretches punch holes that the pointer has to walk back to.
        for (int n = 0; n < 1800; n++)
        begin
            set_idling(n / 90);
            if (n < 1200)
            begin
                alloc_pct = 96;
            end
            else if (n < 1500)
            begin
                alloc_pct = 50;
            end
            else
            begin
                alloc_pct = 35;
            end
            if ($urandom_range(99) < alloc_pct)
            begin
                send_request(FUNC_ALLOC, REL_W'($urandom));
                if (live_ids < NUM_IDS)
                begin
                    live_ids++;
                end
            end
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    id = REL_W'($urandom);
                end
                else
                begin
                    id = REL_W'($urandom_range((live_ids + 4 < NUM_IDS) ? live_ids + 4
                                                                         : NUM_IDS - 1));
                end
                send_request(FUNC_FREE, id);
                if (live_ids > 0)
                begin
                    live_ids--;
                end
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("lowest_free_id_allocator regression: pass");
        end
        else
        begin
            $display("lowest_free_id_allocator regression: fail");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("lowest_free_id_allocator regression: fail");
        $finish;
    end

endmodule
